/* hdl/bsfe_pkg.sv */
`timescale 1ns / 1ps

package bsfe_pkg;

  // Configuration register indexes on the write port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_END    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOR_ESCAPE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE      = 3'd6;

  localparam int SIZE_W = 11;
  localparam int CFG_DATA_W = 11;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_START_FLAG      = 8'h7E;
  localparam logic [7:0] RST_END_FLAG        = 8'h7E;
  localparam logic [7:0] RST_ESCAPE_BYTE     = 8'h7D;
  localparam logic [7:0] RST_CODE_FOR_START  = 8'h02;
  localparam logic [7:0] RST_CODE_FOR_END    = 8'h02;
  localparam logic [7:0] RST_CODE_FOR_ESCAPE = 8'h01;
  localparam logic [SIZE_W-1:0] RST_CHUNK_SIZE = 11'd256;

  // Depth of the queue between the classifier and the byte sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef struct packed {
    logic [7:0]        start_flag;
    logic [7:0]        end_flag;
    logic [7:0]        escape_byte;
    logic [7:0]        code_for_start;
    logic [7:0]        code_for_end;
    logic [7:0]        code_for_escape;
    logic [SIZE_W-1:0] chunk_size;
  } cfg_t;

  // One classified input item.
  typedef struct packed {
    logic       first;
    logic       esc;
    logic [7:0] body;
    logic       last;
    logic       full;
  } entry_t;

  // Pieces of one item, in the order in which they are sent.
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

endpackage

/* hdl/bsfe_front.sv */
`timescale 1ns / 1ps

module bsfe_front #(
  parameter int MAX_CHUNK = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  bsfe_pkg::cfg_t     cfg,
  input  logic [7:0]         data_byte,
  input  logic               first_in_frame,
  input  logic               last_in_frame,
  input  logic               push,
  input  logic               q_full,
  output logic               q_write,
  output bsfe_pkg::entry_t   q_entry
);

  localparam int CNT_W = bsfe_pkg::SIZE_W + 2;

  logic [bsfe_pkg::SIZE_W-1:0] chunk_count;
  logic [bsfe_pkg::SIZE_W-1:0] chunk_count_next;
  logic [CNT_W-1:0]            size_eff;
  logic [CNT_W-1:0]            cnt_base;
  logic [CNT_W-1:0]            cnt_after;
  logic                        esc;
  logic [7:0]                  body;
  logic                        fill;

  assign q_write = push && !q_full;

  // Escape test, in priority order: start flag, end flag, escape byte.
  always_comb begin
    esc  = 1'b1;
    body = data_byte;
    if (data_byte == cfg.start_flag) begin
      body = cfg.code_for_start;
    end else if (data_byte == cfg.end_flag) begin
      body = cfg.code_for_end;
    end else if (data_byte == cfg.escape_byte) begin
      body = cfg.code_for_escape;
    end else begin
      esc = 1'b0;
    end
  end

  // Chunk size limited to the largest supported chunk.
  always_comb begin
    if (32'(cfg.chunk_size) > MAX_CHUNK) begin
      size_eff = CNT_W'(MAX_CHUNK);
    end else begin
      size_eff = CNT_W'(cfg.chunk_size);
    end
  end

  // Byte count of the chunk after this item's payload bytes.
  always_comb begin
    cnt_base  = first_in_frame ? '0 : CNT_W'(chunk_count);
    cnt_after = cnt_base + CNT_W'(first_in_frame) + (esc ? CNT_W'(2) : CNT_W'(1));
    fill      = (cnt_after + CNT_W'(2)) >= size_eff;
    if (last_in_frame || fill) begin
      chunk_count_next = '0;
    end else begin
      chunk_count_next = cnt_after[bsfe_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    q_entry.first = first_in_frame;
    q_entry.esc   = esc;
    q_entry.body  = body;
    q_entry.last  = last_in_frame;
    q_entry.full  = fill && !last_in_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
    end else if (q_write) begin
      chunk_count <= chunk_count_next;
    end
  end

endmodule

/* hdl/bsfe_queue.sv */
`timescale 1ns / 1ps

module bsfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  bsfe_pkg::entry_t wr_entry,
  output logic             q_full,
  input  logic             rd_en,
  output logic             rd_valid,
  output bsfe_pkg::entry_t rd_entry
);

  bsfe_pkg::entry_t                  slots [bsfe_pkg::QUEUE_DEPTH];
  logic [bsfe_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [bsfe_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [bsfe_pkg::QUEUE_CNT_W-1:0]  fill_count;
  logic                              do_wr;
  logic                              do_rd;

  assign q_full   = fill_count == bsfe_pkg::QUEUE_CNT_W'(bsfe_pkg::QUEUE_DEPTH);
  assign rd_valid = fill_count != '0;
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill_count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + bsfe_pkg::QUEUE_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + bsfe_pkg::QUEUE_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill_count <= fill_count + bsfe_pkg::QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill_count <= fill_count - bsfe_pkg::QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/bsfe_back.sv */
`timescale 1ns / 1ps

module bsfe_back (
  input  logic             clk,
  input  logic             rst,
  input  bsfe_pkg::cfg_t   cfg,
  input  logic             rd_valid,
  input  bsfe_pkg::entry_t rd_entry,
  output logic             rd_en,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             chunk_full,
  output logic             frame_done
);

  bsfe_pkg::phase_t phase;
  bsfe_pkg::phase_t cur_phase;
  bsfe_pkg::phase_t nxt_phase;
  logic             started;
  logic             final_piece;
  logic             advance;
  logic             out_valid;
  logic [7:0]       piece_byte;

  assign empty   = !out_valid;
  assign advance = rd_valid && (!out_valid || pop);
  assign rd_en   = advance && final_piece;

  // Piece to send now: a fresh head starts at its first applicable piece.
  always_comb begin
    if (started) begin
      cur_phase = phase;
    end else if (rd_entry.first) begin
      cur_phase = bsfe_pkg::PH_START;
    end else if (rd_entry.esc) begin
      cur_phase = bsfe_pkg::PH_ESC;
    end else begin
      cur_phase = bsfe_pkg::PH_BODY;
    end
  end

  // Following piece, and whether the current one closes the item.
  always_comb begin
    nxt_phase   = bsfe_pkg::PH_BODY;
    final_piece = 1'b0;
    piece_byte  = rd_entry.body;
    unique case (cur_phase)
      bsfe_pkg::PH_START: begin
        piece_byte = cfg.start_flag;
        nxt_phase  = rd_entry.esc ? bsfe_pkg::PH_ESC : bsfe_pkg::PH_BODY;
      end
      bsfe_pkg::PH_ESC: begin
        piece_byte = cfg.escape_byte;
        nxt_phase  = bsfe_pkg::PH_BODY;
      end
      bsfe_pkg::PH_BODY: begin
        piece_byte  = rd_entry.body;
        nxt_phase   = bsfe_pkg::PH_END;
        final_piece = !rd_entry.last;
      end
      bsfe_pkg::PH_END: begin
        piece_byte  = cfg.end_flag;
        final_piece = 1'b1;
      end
      default: begin
        final_piece = 1'b1;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      phase   <= bsfe_pkg::PH_BODY;
    end else if (advance) begin
      started <= !final_piece;
      phase   <= nxt_phase;
    end
  end

  // Output register: holds a result until it is popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= piece_byte;
      run_last   <= final_piece;
      chunk_full <= final_piece && rd_entry.full;
      frame_done <= cur_phase == bsfe_pkg::PH_END;
    end
  end

endmodule

/* hdl/byte_stuffing_frame_encoder.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Payload
// input    in         push / full       data_byte, first_in_frame, last_in_frame
// result   out        empty / pop       out_byte, run_last, chunk_full, frame_done
// config   in         cfg_write         cfg_index, cfg_data
//
// The byte sequencer sends one result byte per cycle unless the output holds;
// an item gives one to four bytes (start flag, escape pair, end flag).
// A four-entry queue lets the classifier take items while the sequencer works.
// Reset restores the default flags and chunk size, clears the chunk count and
// empties the queue and the output register.
// With pop low the output register holds; the queue then fills and full rises.
module byte_stuffing_frame_encoder #(
  parameter int MAX_CHUNK = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        data_byte,
  input  logic                              first_in_frame,
  input  logic                              last_in_frame,
  input  logic                              push,
  output logic                              full,
  output logic [7:0]                        out_byte,
  output logic                              run_last,
  output logic                              chunk_full,
  output logic                              frame_done,
  output logic                              empty,
  input  logic                              pop,
  input  logic                              cfg_write,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bsfe_pkg::cfg_t   cfg;
  bsfe_pkg::entry_t wr_entry;
  bsfe_pkg::entry_t rd_entry;
  logic             q_write;
  logic             rd_en;
  logic             rd_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_flag      <= bsfe_pkg::RST_START_FLAG;
      cfg.end_flag        <= bsfe_pkg::RST_END_FLAG;
      cfg.escape_byte     <= bsfe_pkg::RST_ESCAPE_BYTE;
      cfg.code_for_start  <= bsfe_pkg::RST_CODE_FOR_START;
      cfg.code_for_end    <= bsfe_pkg::RST_CODE_FOR_END;
      cfg.code_for_escape <= bsfe_pkg::RST_CODE_FOR_ESCAPE;
      cfg.chunk_size      <= bsfe_pkg::RST_CHUNK_SIZE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bsfe_pkg::CFG_START_FLAG:      cfg.start_flag      <= cfg_data[7:0];
        bsfe_pkg::CFG_END_FLAG:        cfg.end_flag        <= cfg_data[7:0];
        bsfe_pkg::CFG_ESCAPE_BYTE:     cfg.escape_byte     <= cfg_data[7:0];
        bsfe_pkg::CFG_CODE_FOR_START:  cfg.code_for_start  <= cfg_data[7:0];
        bsfe_pkg::CFG_CODE_FOR_END:    cfg.code_for_end    <= cfg_data[7:0];
        bsfe_pkg::CFG_CODE_FOR_ESCAPE: cfg.code_for_escape <= cfg_data[7:0];
        bsfe_pkg::CFG_CHUNK_SIZE:      cfg.chunk_size      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Classifier and chunk counter.
  bsfe_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .data_byte      (data_byte),
    .first_in_frame (first_in_frame),
    .last_in_frame  (last_in_frame),
    .push           (push),
    .q_full         (full),
    .q_write        (q_write),
    .q_entry        (wr_entry)
  );

  // Queue of classified items.
  bsfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_write),
    .wr_entry (wr_entry),
    .q_full   (full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

  // Byte sequencer and output register.
  bsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rd_valid   (rd_valid),
    .rd_entry   (rd_entry),
    .rd_en      (rd_en),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .chunk_full (chunk_full),
    .frame_done (frame_done)
  );

`ifndef SYNTHESIS
  // Nothing is shown in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // The closing end flag is always the last byte of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> run_last)
    else $error("end flag not on the final byte of its item");

  // A chunk is never marked full on the byte that closes the frame.
  a_full_not_done: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(chunk_full && frame_done))
    else $error("chunk full marked on a frame end");

  // A full chunk mark only comes with the final byte of an item.
  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && chunk_full) |-> run_last)
    else $error("chunk full marked before the final byte");
`endif

endmodule
